// ===== sv/btff_pkg.sv =====
// ----------------------------------------------------------------------------
// btff_pkg: shared types and constants of the boundary tag allocator
// Word formats, tag layout and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package btff_pkg;

	localparam int POOL_BYTES = 1024;
	localparam int TAG_BYTES  = 4;
	localparam int TWO_TAGS   = 2 * TAG_BYTES;
	localparam int ADDR_W     = $clog2(POOL_BYTES);
	localparam int POS_W      = ADDR_W + 1;
	localparam int SIZE_W     = 10;
	localparam int REQ_W      = 11;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic              command;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] block_offset;
	} in_word_t;

	typedef struct packed {
		logic              success;
		logic [ADDR_W-1:0] payload_offset;
	} out_word_t;

	typedef struct packed {
		logic              alloc;
		logic [SIZE_W-1:0] size;
	} tag_t;

	typedef struct packed {
		logic load;
		logic init_wr;
		logic rd_pos;
		logic rd_right;
		logic step;
		logic mark;
		logic right_take;
		logic put_split;
		logic put_alloc;
		logic put_free;
		logic wr_head;
		logic wr_foot;
		logic res_load;
		logic res_ok;
	} dp_cmd_t;

	typedef struct packed {
		logic free_cmd;
		logic off_low;
		logic pos_end;
		logic pos_past;
		logic at_target;
		logic tag_free;
		logic fit;
		logic split;
		logic right_in;
		logic out_busy;
	} dp_sts_t;

endpackage

// ===== sv/btff_datapath.sv =====
// ----------------------------------------------------------------------------
// btff_datapath: tag store and walk registers
// Holds the tag memory, the walk position, neighbor bookkeeping, the chunk
// write register and the result register.
// ----------------------------------------------------------------------------
module btff_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  btff_pkg::in_word_t  req,
	input  btff_pkg::dp_cmd_t   cmd,
	output btff_pkg::dp_sts_t   sts,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output btff_pkg::out_word_t rsp
);
	import btff_pkg::*;

	tag_t              mem [POOL_BYTES];
	tag_t              rd_q;
	logic              free_q;
	logic [REQ_W-1:0]  req_size_q;
	logic [ADDR_W-1:0] boff_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  prev_pos_q;
	logic [SIZE_W-1:0] prev_sz_q;
	logic              prev_free_q;
	logic              have_prev_q;
	logic [SIZE_W-1:0] cur_sz_q;
	logic [POS_W-1:0]  right_q;
	logic [POS_W-1:0]  right_add_q;
	logic [POS_W-1:0]  put_head_q;
	logic [SIZE_W-1:0] put_size_q;
	logic              put_alloc_q;
	logic              rsp_valid_q;
	out_word_t         rsp_q;

	logic [POS_W-1:0]  target;
	logic [POS_W-1:0]  next_pos;
	logic [REQ_W:0]    sz_ext;
	logic [REQ_W:0]    req_ext;
	logic              fit_size;
	logic              split;
	logic [POS_W:0]    foot_addr;
	logic              foot_in;
	logic [POS_W-1:0]  left_add;
	logic [POS_W-1:0]  free_size;
	logic              left_merge;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	tag_t              wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;

	assign target     = POS_W'(boff_q) - POS_W'(TAG_BYTES);
	assign next_pos   = pos_q + POS_W'(rd_q.size) + POS_W'(TWO_TAGS);
	assign sz_ext     = (REQ_W+1)'(rd_q.size);
	assign req_ext    = (REQ_W+1)'(req_size_q);
	assign fit_size   = sz_ext >= req_ext;
	assign split      = sz_ext >= req_ext + (REQ_W+1)'(TWO_TAGS);
	assign foot_addr  = (POS_W+1)'(put_head_q) + (POS_W+1)'(TAG_BYTES)
		+ (POS_W+1)'(put_size_q);
	assign foot_in    = foot_addr < (POS_W+1)'(POOL_BYTES);
	assign left_merge = have_prev_q && prev_free_q;
	assign left_add   = left_merge ? POS_W'(prev_sz_q) + POS_W'(TWO_TAGS) : '0;
	assign free_size  = POS_W'(cur_sz_q) + right_add_q + left_add;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cmd.init_wr) begin
			wr_en        = 1'b1;
			wr_data.size = SIZE_W'(POOL_BYTES - TWO_TAGS);
		end else if (cmd.wr_head) begin
			wr_en   = 1'b1;
			wr_addr = put_head_q[ADDR_W-1:0];
			wr_data = '{alloc: put_alloc_q, size: put_size_q};
		end else if (cmd.wr_foot) begin
			wr_en   = foot_in;
			wr_addr = foot_addr[ADDR_W-1:0];
			wr_data = '{alloc: put_alloc_q, size: put_size_q};
		end
	end

	assign rd_en   = cmd.rd_pos || cmd.rd_right;
	assign rd_addr = cmd.rd_right ? right_q[ADDR_W-1:0] : pos_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			free_q      <= req.command;
			req_size_q  <= req.request_size;
			boff_q      <= req.block_offset;
			pos_q       <= '0;
			have_prev_q <= 1'b0;
		end
		if (cmd.step) begin
			prev_pos_q  <= pos_q;
			prev_sz_q   <= rd_q.size;
			prev_free_q <= !rd_q.alloc;
			have_prev_q <= 1'b1;
			pos_q       <= next_pos;
		end
		if (cmd.mark) begin
			cur_sz_q    <= rd_q.size;
			right_q     <= next_pos;
			right_add_q <= '0;
		end
		if (cmd.right_take) begin
			right_add_q <= rd_q.alloc ? '0 : POS_W'(rd_q.size) + POS_W'(TWO_TAGS);
		end
		if (cmd.put_split) begin
			put_head_q  <= pos_q + POS_W'(req_size_q) + POS_W'(TWO_TAGS);
			put_size_q  <= SIZE_W'(sz_ext - req_ext - (REQ_W+1)'(TWO_TAGS));
			put_alloc_q <= 1'b0;
		end
		if (cmd.put_alloc) begin
			put_head_q  <= pos_q;
			put_size_q  <= split ? SIZE_W'(req_size_q) : rd_q.size;
			put_alloc_q <= 1'b1;
		end
		if (cmd.put_free) begin
			put_head_q  <= left_merge ? prev_pos_q : pos_q;
			put_size_q  <= SIZE_W'(free_size);
			put_alloc_q <= 1'b0;
		end
		if (cmd.res_load) begin
			rsp_q.success        <= cmd.res_ok;
			rsp_q.payload_offset <= (cmd.res_ok && free_q == CMD_ALLOC)
				? ADDR_W'(pos_q + POS_W'(TAG_BYTES)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.free_cmd  = free_q == CMD_FREE;
	assign sts.off_low   = boff_q < ADDR_W'(TAG_BYTES);
	assign sts.pos_end   = pos_q >= POS_W'(POOL_BYTES);
	assign sts.pos_past  = pos_q > target;
	assign sts.at_target = pos_q == target;
	assign sts.tag_free  = !rd_q.alloc;
	assign sts.fit       = !rd_q.alloc && fit_size;
	assign sts.split     = split;
	assign sts.right_in  = right_q < POS_W'(POOL_BYTES);
	assign sts.out_busy  = rsp_valid_q && rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/btff_ctrl.sv =====
// ----------------------------------------------------------------------------
// btff_ctrl: allocator sequencer
// Runs the store setup, the first-fit walk, the free walk with neighbor
// merge and the chunk tag writes.
// ----------------------------------------------------------------------------
module btff_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  btff_pkg::dp_sts_t sts,
	output btff_pkg::dp_cmd_t cmd
);
	import btff_pkg::*;

	typedef enum logic [11:0] {
		S_INIT = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_RD   = 12'b000000000100,
		S_EV   = 12'b000000001000,
		S_RR   = 12'b000000010000,
		S_ER   = 12'b000000100000,
		S_PF   = 12'b000001000000,
		S_W1H  = 12'b000010000000,
		S_W1F  = 12'b000100000000,
		S_W2H  = 12'b001000000000,
		S_W2F  = 12'b010000000000,
		S_FIN  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   ok_q, ok_d;

	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				if ((sts.free_cmd && (sts.off_low || sts.pos_past)) || sts.pos_end) begin
					ok_d    = 1'b0;
					state_d = S_FIN;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = S_EV;
				end
			end
			S_EV: begin
				if (!sts.free_cmd) begin
					if (sts.fit && sts.split) begin
						cmd.put_split = 1'b1;
						state_d       = S_W1H;
					end else if (sts.fit) begin
						cmd.put_alloc = 1'b1;
						state_d       = S_W2H;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_RD;
					end
				end else if (sts.at_target) begin
					if (sts.tag_free) begin
						ok_d    = 1'b0;
						state_d = S_FIN;
					end else begin
						cmd.mark = 1'b1;
						state_d  = S_RR;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RR: begin
				if (sts.right_in) begin
					cmd.rd_right = 1'b1;
					state_d      = S_ER;
				end else begin
					state_d = S_PF;
				end
			end
			S_ER: begin
				cmd.right_take = 1'b1;
				state_d        = S_PF;
			end
			S_PF: begin
				cmd.put_free = 1'b1;
				state_d      = S_W2H;
			end
			S_W1H: begin
				cmd.wr_head = 1'b1;
				state_d     = S_W1F;
			end
			S_W1F: begin
				cmd.wr_foot   = 1'b1;
				cmd.put_alloc = 1'b1;
				state_d       = S_W2H;
			end
			S_W2H: begin
				cmd.wr_head = 1'b1;
				state_d     = S_W2F;
			end
			S_W2F: begin
				cmd.wr_foot = 1'b1;
				ok_d        = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_ok   = ok_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

endmodule

// ===== sv/boundary_tag_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator: first-fit chunk allocator over a pool
// Header and footer tags per chunk; split on allocate, merge on free.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid, req_stall, req): one command word, allocate or
//   free. rsp channel (rsp_valid, rsp_stall, rsp): one result word for
//   every command, in order.
//   One command at a time. The walk visits chunks from offset 0: a tag
//   memory read, which is registered, then an evaluate per chunk. Allocate:
//   on success the split-off free remainder's tags, if any, and then the
//   allocated chunk's header and footer are written; on failure the walk
//   stops at the end check. Free: the walk runs to the target chunk, reads
//   the right neighbor if it lies in the pool, then writes the merged
//   chunk's header and footer; an offset below the first payload is rejected
//   before any tag read. A load step precedes the walk, a result step ends it.
//   Reset: after arst_n releases, one cycle writes the header of the single
//   free chunk that spans the pool; req_stall is high during that cycle.
//   The result sits in an output register; while the receiver stalls it is
//   held and the next command is still accepted, then finishes its walk
//   and waits for the register to empty.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  btff_pkg::in_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output btff_pkg::out_word_t rsp
);
	import btff_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	btff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	btff_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== sv/btff_checker.sv =====
// ----------------------------------------------------------------------------
// btff_checker: port-level checks for the allocator
// Handshake hold rules, one-command-at-a-time and result offset range.
// ----------------------------------------------------------------------------
module btff_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input btff_pkg::out_word_t rsp
);
	import btff_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("rsp_valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("rsp word changed while stalled");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second command taken before walk");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.payload_offset != '0 |->
			rsp.success && rsp.payload_offset >= ADDR_W'(TAG_BYTES))
		else $error("bad payload offset");

endmodule

bind boundary_tag_first_fit_allocator btff_checker u_btff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== tb/tb_boundary_tag_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_boundary_tag_first_fit_allocator: self-checking bench for the allocator
// Sends allocate and free words on the req channel. A shadow copy of the
// chunk tags predicts every result, and each word on the rsp channel is
// checked against it in order. Three phases mix sender and receiver idling,
// and each phase ends with the sender held until all results are back.
// ----------------------------------------------------------------------------
module tb_boundary_tag_first_fit_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import btff_pkg::*;

	localparam int RANDOM_WORDS   = 1131;
	localparam int DRAIN_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRINT_LIMIT    = 100;

	class tag_shadow;
		tag_t        tag_mem [POOL_BYTES];
		out_word_t   expected_results [$];
		int unsigned mismatches;
		int unsigned results_seen;

		function new();
			foreach (tag_mem[i]) tag_mem[i] = '0;
			put_chunk(0, POOL_BYTES - TWO_TAGS, 1'b0);
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void put_chunk(int head, int len, logic busy);
			tag_t w;
			int   foot;
			w.alloc = busy;
			w.size  = SIZE_W'(len);
			foot    = head + TAG_BYTES + len;
			if (head < POOL_BYTES) tag_mem[head] = w;
			if (foot < POOL_BYTES) tag_mem[foot] = w;
		endfunction

		function out_word_t take_command(in_word_t w);
			out_word_t res;
			tag_t      t;
			int        pos, sz, want, target, head, len, right;
			int        left_pos, left_size;
			bit        left_free;
			res       = '0;
			pos       = 0;
			left_free = 1'b0;
			left_pos  = 0;
			left_size = 0;
			if (w.command == CMD_ALLOC) begin
				want = int'(w.request_size);
				while (pos < POOL_BYTES) begin
					t  = tag_mem[pos];
					sz = int'(t.size);
					if (!t.alloc && sz >= want) begin
						if (sz - want >= TWO_TAGS) begin
							put_chunk(pos + TWO_TAGS + want, sz - want - TWO_TAGS, 1'b0);
							put_chunk(pos, want, 1'b1);
						end else begin
							put_chunk(pos, sz, 1'b1);
						end
						res.success        = 1'b1;
						res.payload_offset = ADDR_W'(pos + TAG_BYTES);
						break;
					end
					pos += sz + TWO_TAGS;
				end
			end else if (int'(w.block_offset) >= TAG_BYTES) begin
				target = int'(w.block_offset) - TAG_BYTES;
				while (pos < POOL_BYTES && pos <= target) begin
					t  = tag_mem[pos];
					sz = int'(t.size);
					if (pos == target) begin
						if (t.alloc) begin
							head  = pos;
							len   = sz;
							right = pos + TWO_TAGS + sz;
							if (right < POOL_BYTES && !tag_mem[right].alloc)
								len += int'(tag_mem[right].size) + TWO_TAGS;
							if (left_free) begin
								head = left_pos;
								len += left_size + TWO_TAGS;
							end
							put_chunk(head, len, 1'b0);
							res.success = 1'b1;
						end
						break;
					end
					left_free = !t.alloc;
					left_pos  = pos;
					left_size = sz;
					pos += sz + TWO_TAGS;
				end
			end
			expected_results.push_back(res);
			return res;
		endfunction

		task flag_mismatch(string what);
			if (mismatches < PRINT_LIMIT)
				$display("%0t MISMATCH %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(out_word_t got);
			out_word_t exp_word;
			results_seen++;
			if (expected_results.size() == 0) begin
				flag_mismatch($sformatf("word %0d arrived with none expected", results_seen));
				return;
			end
			exp_word = expected_results.pop_front();
			if (got.success !== exp_word.success)
				flag_mismatch($sformatf("word %0d success %b, expected %b",
					results_seen, got.success, exp_word.success));
			if (got.payload_offset !== exp_word.payload_offset)
				flag_mismatch($sformatf("word %0d payload_offset %0d, expected %0d",
					results_seen, got.payload_offset, exp_word.payload_offset));
		endtask
	endclass

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_word_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_word_t rsp;

	int        send_idle = 0;
	int        recv_idle = 0;
	int        live_offsets [$];
	int        n_alloc = 0, n_alloc_fail = 0, n_free = 0, n_free_reject = 0;
	tag_shadow shadow = new();

	boundary_tag_first_fit_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_idle);
		if (arst_n && rsp_valid && !rsp_stall)
			shadow.check_result(rsp);
	end

	function automatic in_word_t make_word(logic cmd, int len, int off);
		in_word_t w;
		w.command      = cmd;
		w.request_size = (cmd == CMD_ALLOC) ? REQ_W'(len) : REQ_W'($urandom_range(1024));
		w.block_offset = (cmd == CMD_FREE) ? ADDR_W'(off) : ADDR_W'($urandom);
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		out_word_t res;
		int        idx;
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		res = shadow.take_command(w);
		if (w.command == CMD_ALLOC) begin
			n_alloc++;
			if (res.success) live_offsets.push_back(int'(res.payload_offset));
			else n_alloc_fail++;
		end else begin
			n_free++;
			if (!res.success) n_free_reject++;
			idx = 0;
			while (idx < live_offsets.size()) begin
				if (res.success && live_offsets[idx] == int'(w.block_offset))
					live_offsets.delete(idx);
				else
					idx++;
			end
		end
	endtask

	task automatic send_random();
		int r, len;
		r = $urandom_range(99);
		if (r < 42 && live_offsets.size() != 0) begin
			send_word(make_word(CMD_FREE, 0,
				live_offsets[$urandom_range(live_offsets.size() - 1)]));
		end else if (r >= 42 && r < 50) begin
			send_word(make_word(CMD_FREE, 0, $urandom_range(POOL_BYTES - 1)));
		end else begin
			r = $urandom_range(99);
			if (r < 12) len = $urandom_range(7);
			else if (r < 80) len = $urandom_range(64, 1);
			else if (r < 95) len = $urandom_range(300, 65);
			else len = $urandom_range(1024, 301);
			send_word(make_word(CMD_ALLOC, len, 0));
		end
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (shadow.expected_results.size() != 0) @(posedge clk);
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
			else quiet++;
		end
		$display("Timeout: %0d cycles without a word moving", WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int phase;
		repeat (8) @(posedge clk);
		arst_n    <= 1'b1;
		send_idle = 13;
		recv_idle = 75;

		send_word(make_word(CMD_ALLOC, 1024, 0));
		send_word(make_word(CMD_ALLOC, POOL_BYTES - TWO_TAGS, 0));
		send_word(make_word(CMD_ALLOC, 0, 0));
		send_word(make_word(CMD_FREE, 0, 0));
		send_word(make_word(CMD_FREE, 0, TAG_BYTES - 1));
		send_word(make_word(CMD_FREE, 0, TAG_BYTES));
		send_word(make_word(CMD_FREE, 0, TAG_BYTES));
		send_word(make_word(CMD_ALLOC, POOL_BYTES - TWO_TAGS - 6, 0));
		send_word(make_word(CMD_FREE, 0, TAG_BYTES));
		send_word(make_word(CMD_ALLOC, 0, 0));
		send_word(make_word(CMD_ALLOC, 100, 0));
		send_word(make_word(CMD_ALLOC, 200, 0));
		send_word(make_word(CMD_FREE, 0, 13));
		send_word(make_word(CMD_FREE, 0, 12));
		send_word(make_word(CMD_FREE, 0, TAG_BYTES));
		send_word(make_word(CMD_ALLOC, 1023, 0));
		send_word(make_word(CMD_FREE, 0, 120));
		send_word(make_word(CMD_FREE, 0, 1023));
		send_word(make_word(CMD_ALLOC, POOL_BYTES - TWO_TAGS, 0));
		send_word(make_word(CMD_FREE, 0, TAG_BYTES));
		hold_until_drained();

		for (phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 13 : (phase == 1) ? 75 : 0;
			recv_idle = (phase == 0) ? 75 : (phase == 1) ? 13 : 0;
			repeat (RANDOM_WORDS / 3) send_random();
			hold_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.expected_results.size() != 0)
			shadow.flag_mismatch($sformatf("%0d results never arrived",
				shadow.expected_results.size()));
		$display("Ran %0d allocates (%0d found no room) and %0d frees (%0d rejected)",
			n_alloc, n_alloc_fail, n_free, n_free_reject);
		$display("Checked %0d result words across three idle mixes", shadow.results_seen);
		if (shadow.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
